FILE: rtl/core/wmof_pkg.sv
// Shared constants and config register codes for the window mean outlier flagger.
`timescale 1ns / 1ps

package wmof_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;

  localparam int ELEV_W = 15;
  localparam int RAD_W  = 4;
  localparam int FACT_W = 16;

  // store address, sample count, pending count, sample age
  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int PEND_W = $clog2(MAX_RADIUS + 2);
  localparam int AGE_W  = $clog2(MAX_RADIUS + 1);
  // fetch counter: one slot for the judged sample plus the whole window
  localparam int J_W    = $clog2(STORE_DEPTH + 2);
  localparam int IDX_W  = J_W + 2;

  localparam int SUM_W  = ELEV_W + $clog2(STORE_DEPTH);
  localparam int MAG_W  = SUM_W - 1;
  localparam int DIV_W  = $clog2(STORE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'd1;

  localparam logic [RAD_W-1:0]  RADIUS_RST = 4'd8;
  localparam logic [FACT_W-1:0] FACTOR_RST = 16'd32;

endpackage

FILE: rtl/core/wmof_if.sv
// Valid/ready channel interfaces: sample input, result output, config write.
`timescale 1ns / 1ps

interface wmof_in_if;
  import wmof_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] elevation;
  logic                     segment_end;
  modport source (output valid, elevation, segment_end, input ready);
  modport sink   (input valid, elevation, segment_end, output ready);
endinterface

interface wmof_out_if;
  import wmof_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] sample_value;
  logic                     outlier;
  logic                     last_of_run;
  modport source (output valid, sample_value, outlier, last_of_run, input ready);
  modport sink   (input valid, sample_value, outlier, last_of_run, output ready);
endinterface

interface wmof_cfg_if;
  import wmof_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/window_mean_outlier_flagger.sv
// Top level: sample store sequencer, window sum, mean divide and outlier compare.
//
//   channel     dir  handshake      payload
//   in_item_i   in   valid/ready    elevation, segment_end
//   result_o    out  valid/ready    sample_value, outlier, last_of_run
//   cfg_i       in   valid/ready    index (0 radius, 1 factor), data
//
// One item at a time. A stored item goes to the check state; each sample it judges then
// takes 2r+2 reads of the single store read port, then the 19-step divider,
// compare and output load. A segment end judges up to 16 samples.
// Reset clears state, write pointer, sample and pending counts and output valid; store contents stay undefined.
// A stalled result_o holds the next result in its compare stage; in_item_i stays
// low until all results of the current item have been handed to the output register.
`timescale 1ns / 1ps

module window_mean_outlier_flagger (
  input logic         clk_i,
  input logic         rst_ni,
  wmof_in_if.sink     in_item_i,
  wmof_out_if.source  result_o,
  wmof_cfg_if.sink    cfg_i
);
  import wmof_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_EVAL   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [RAD_W-1:0]  radius_q;
  logic [FACT_W-1:0] factor_q;
  logic [AW-1:0]     wp_q, wp_next;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              end_q, end_d;
  logic              last_q, last_d;
  logic [AGE_W-1:0]  age_q, age_d;
  logic [J_W-1:0]    j_q, j_d;

  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [ELEV_W-1:0] e_q, e_d;
  logic                     flag_q, flag_d;

  logic                     out_vld_q;
  logic signed [ELEV_W-1:0] out_val_q;
  logic                     out_flag_q, out_last_q;
  logic                     out_load;

  logic              in_acc, cfg_acc;
  logic [AGE_W-1:0]  eff_r;
  logic [J_W-1:0]    j_last;
  logic [AW-1:0]     hi;
  logic [IDX_W-1:0]  idx_raw;
  logic [AW-1:0]     idx_c;
  logic [AW-1:0]     rd_addr;
  logic [ELEV_W-1:0] rd_data;
  logic [SUM_W-1:0]  rd_ext;
  logic [SUM_W-1:0]  sum_abs;
  logic              div_start, div_done;
  logic [MAG_W-1:0]  quot;
  logic [SUM_W-1:0]  e_abs, diff, diff_abs;

  assign in_acc  = in_item_i.valid && in_item_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;

  assign eff_r  = (32'(radius_q) > MAX_RADIUS) ? AGE_W'(MAX_RADIUS) : AGE_W'(radius_q);
  assign j_last = J_W'({eff_r, 1'b1});
  assign wp_next = (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : wp_q + AW'(1);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      factor_q <= FACTOR_RST;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        REG_RADIUS: radius_q <= cfg_i.data[RAD_W-1:0];
        REG_FACTOR: factor_q <= cfg_i.data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read address: slot 0 is the judged sample, then window offsets from +r down to -r.
  // Offsets are clamped to the samples of the current segment.
  assign hi = (seen_q == '0) ? '0 : AW'(seen_q - CNT_W'(1));

  always_comb begin
    if (j_q == '0) begin
      idx_raw = IDX_W'(age_q);
    end else begin
      idx_raw = IDX_W'(age_q) + IDX_W'(eff_r) + IDX_W'(1) - IDX_W'(j_q);
    end
    if (idx_raw[IDX_W-1]) begin
      idx_c = '0;
    end else if (idx_raw > IDX_W'(hi)) begin
      idx_c = hi;
    end else begin
      idx_c = AW'(idx_raw);
    end
    if (idx_c > wp_q) begin
      rd_addr = AW'((AW+1)'(wp_q) + (AW+1)'(STORE_DEPTH) - (AW+1)'(idx_c));
    end else begin
      rd_addr = wp_q - idx_c;
    end
  end

  wmof_store u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_next),
    .wdata_i (in_item_i.elevation),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_ext  = {{(SUM_W-ELEV_W){rd_data[ELEV_W-1]}}, rd_data};
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign div_start = (state_q == S_DSTART);

  wmof_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs[MAG_W-1:0]),
    .divisor_i  (DIV_W'({eff_r, 1'b1})),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // | |e| - |mean| | against factor; quotient is already |mean|
  assign e_abs    = e_q[ELEV_W-1] ? SUM_W'(-SUM_W'(e_q)) : SUM_W'(e_q);
  assign diff     = e_abs - SUM_W'(quot);
  assign diff_abs = diff[SUM_W-1] ? SUM_W'(-diff) : diff;

  assign out_load = (state_q == S_EMIT) && (!out_vld_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    pend_d  = pend_q;
    end_d   = end_q;
    last_d  = last_q;
    age_d   = age_q;
    j_d     = j_q;
    sum_d   = sum_q;
    e_d     = e_q;
    flag_d  = flag_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (seen_q != CNT_W'(STORE_DEPTH)) seen_d = seen_q + CNT_W'(1);
          if (pend_q != PEND_W'(MAX_RADIUS + 1)) pend_d = pend_q + PEND_W'(1);
          end_d   = in_item_i.segment_end;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((end_q && pend_q != '0) || (!end_q && pend_q > PEND_W'(eff_r))) begin
          age_d   = AGE_W'(pend_q - PEND_W'(1));
          last_d  = end_q && (pend_q == PEND_W'(1));
          pend_d  = pend_q - PEND_W'(1);
          j_d     = '0;
          sum_d   = '0;
          state_d = S_FETCH;
        end else begin
          if (end_q) seen_d = '0;
          state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        // data for slot j-1 returns while slot j is read
        if (j_q == J_W'(1)) begin
          e_d = ELEV_W'(rd_data);
        end else if (j_q != '0) begin
          sum_d = sum_q + rd_ext;
        end
        if (j_q == j_last) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + J_W'(1);
        end
      end
      S_DRAIN: begin
        sum_d   = sum_q + rd_ext;
        state_d = S_DSTART;
      end
      S_DSTART: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = S_EVAL;
      end
      S_EVAL: begin
        flag_d  = diff_abs > SUM_W'(factor_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_d = S_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      seen_q    <= '0;
      pend_q    <= '0;
      end_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      pend_q  <= pend_d;
      end_q   <= end_d;
      if (in_acc) wp_q <= wp_next;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    age_q  <= age_d;
    j_q    <= j_d;
    sum_q  <= sum_d;
    e_q    <= e_d;
    flag_q <= flag_d;
    if (out_load) begin
      out_val_q  <= e_q;
      out_flag_q <= flag_q;
      out_last_q <= last_q;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.sample_value = out_val_q;
  assign result_o.outlier      = out_flag_q;
  assign result_o.last_of_run  = out_last_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_W'(MAX_RADIUS + 1))
    else $error("pending sample count out of range");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CHECK)
    else $error("accepted item not checked next cycle");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide wait");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |-> (pend_q == '0 && end_q))
    else $error("segment flush marked last with samples still pending");

endmodule

FILE: rtl/core/wmof_store.sv
// Sample history memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module wmof_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [wmof_pkg::AW-1:0]        waddr_i,
  input  logic [wmof_pkg::ELEV_W-1:0]    wdata_i,
  input  logic [wmof_pkg::AW-1:0]        raddr_i,
  output logic [wmof_pkg::ELEV_W-1:0]    rdata_o
);
  import wmof_pkg::*;

  logic [ELEV_W-1:0] mem_q [STORE_DEPTH];
  logic [ELEV_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/wmof_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitude by window size.
`timescale 1ns / 1ps

module wmof_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wmof_pkg::MAG_W-1:0] dividend_i,
  input  logic [wmof_pkg::DIV_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [wmof_pkg::MAG_W-1:0] quot_o
);
  import wmof_pkg::*;

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  den_q;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  quot_q;
  logic [DIV_W:0]    trial;
  logic              qbit;

  assign trial = {rem_q, quot_q[MAG_W-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = trial[DIV_W-1:0];
    if (qbit) begin
      rem_d = DIV_W'(trial - {1'b0, den_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_W'(MAG_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[MAG_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
